// File: rtl/core/dqne_pkg.sv
// ----------------------------------------------------------------------------
// dqne_pkg
// Types and constants shared by the DNS query name extractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dqne_pkg;

	localparam int OFFSET_W = 11;
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

	localparam logic [15:0] DNS_PORT = 16'd53;
	localparam logic [7:0]  NAME_DOT = 8'h2E;
	localparam logic [3:0]  IHL_MIN  = 4'd5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_LABEL,
		PH_SKIP
	} phase_t;

	// one result item as it travels from the parser to the output stage
	typedef struct packed {
		logic [7:0]  name_char;
		logic        char_valid;
		logic        name_done;
		logic        name_truncated;
		logic [47:0] source_mac;
		logic [31:0] source_ip;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/dqne_front.sv
// ----------------------------------------------------------------------------
// dqne_front
// Byte parser: tracks frame offset, captures MAC/IP, filters on address, port
// and opcode, and decodes the question name into result items.
// ----------------------------------------------------------------------------
`default_nettype none

module dqne_front #(
	parameter int MAX_NAME_CHARS   = 64,
	parameter int ETH_HEADER_BYTES = 14
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [31:0]          watch_ip,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           frame_byte,
	input  wire logic                 frame_end,
	input  wire dqne_pkg::q_stat_t    q_stat,
	output logic                      push,
	output dqne_pkg::item_t           push_item
);

	localparam int CHAR_W = $clog2(MAX_NAME_CHARS + 1);
	localparam int OW     = dqne_pkg::OFFSET_W;
	localparam logic [OW-1:0]     ETH      = OW'(ETH_HEADER_BYTES);
	localparam logic [OW-1:0]     IP_FIRST = OW'(ETH_HEADER_BYTES + 12);
	localparam logic [OW-1:0]     IP_LAST  = OW'(ETH_HEADER_BYTES + 15);
	localparam logic [OW-1:0]     MAC_LO   = OW'(6);
	localparam logic [OW-1:0]     MAC_HI   = OW'(11);
	localparam logic [CHAR_W-1:0] CHAR_MAX = CHAR_W'(MAX_NAME_CHARS);

	logic [OW-1:0]     off_q;
	logic [3:0]        hw_q;
	logic [47:0]       mac_q;
	logic [31:0]       ip_q;
	logic [7:0]        port_hi_q;
	dqne_pkg::phase_t  phase_q;
	logic [7:0]        left_q;
	logic [CHAR_W-1:0] chars_q;
	logic              first_q;
	logic              trunc_q;

	dqne_pkg::phase_t  phase_step;
	dqne_pkg::phase_t  phase_d;
	logic              done;
	logic              valid;
	logic [7:0]        ch;
	logic [CHAR_W-1:0] chars_d;
	logic              trunc_d;
	logic              first_d;
	logic [7:0]        left_d;
	logic [47:0]       mac_d;
	logic [31:0]       ip_d;
	logic [OW-1:0]     udp;
	logic              in_hdr;
	logic              take;
	logic              accept;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign in_hdr   = (phase_q == dqne_pkg::PH_HEADER);
	assign udp      = ETH + {5'd0, hw_q, 2'b00};
	assign take     = (chars_q < CHAR_MAX);

	assign mac_d = (in_hdr && off_q >= MAC_LO && off_q <= MAC_HI) ?
		{mac_q[39:0], frame_byte} : mac_q;
	assign ip_d  = (in_hdr && off_q >= IP_FIRST && off_q <= IP_LAST) ?
		{ip_q[23:0], frame_byte} : ip_q;

	// next state
	always_comb begin
		phase_step = phase_q;
		unique case (phase_q)
			dqne_pkg::PH_HEADER: begin
				if (off_q == ETH) begin
					if (frame_byte[3:0] < dqne_pkg::IHL_MIN) phase_step = dqne_pkg::PH_SKIP;
				end else if (off_q > ETH) begin
					if (off_q == udp + OW'(3)) begin
						if ({port_hi_q, frame_byte} != dqne_pkg::DNS_PORT || ip_d != watch_ip)
							phase_step = dqne_pkg::PH_SKIP;
					end else if (off_q == udp + OW'(10)) begin
						if (frame_byte[6:3] != 4'd0) phase_step = dqne_pkg::PH_SKIP;
					end else if (off_q == udp + OW'(19)) begin
						phase_step = dqne_pkg::PH_LENGTH;
					end
				end
			end
			dqne_pkg::PH_LENGTH: begin
				phase_step = (frame_byte == 8'd0) ? dqne_pkg::PH_SKIP : dqne_pkg::PH_LABEL;
			end
			dqne_pkg::PH_LABEL: begin
				if (left_q == 8'd1) phase_step = dqne_pkg::PH_LENGTH;
			end
			dqne_pkg::PH_SKIP: begin
				phase_step = dqne_pkg::PH_SKIP;
			end
		endcase

		done = (phase_q == dqne_pkg::PH_LENGTH && frame_byte == 8'd0) ||
			(frame_end && (phase_step == dqne_pkg::PH_LENGTH ||
				phase_step == dqne_pkg::PH_LABEL));

		if (frame_end)
			phase_d = dqne_pkg::PH_HEADER;
		else if (done)
			phase_d = dqne_pkg::PH_SKIP;
		else
			phase_d = phase_step;
	end

	// outputs and name datapath
	always_comb begin
		valid   = 1'b0;
		ch      = 8'd0;
		chars_d = chars_q;
		trunc_d = trunc_q;
		first_d = first_q;
		left_d  = left_q;
		unique case (phase_q)
			dqne_pkg::PH_HEADER: begin
				if (off_q > ETH && off_q == udp + OW'(19)) begin
					first_d = 1'b1;
					chars_d = '0;
					trunc_d = 1'b0;
					left_d  = 8'd0;
				end
			end
			dqne_pkg::PH_LENGTH: begin
				if (frame_byte != 8'd0) begin
					if (!first_q) begin
						if (take) begin
							valid   = 1'b1;
							ch      = dqne_pkg::NAME_DOT;
							chars_d = chars_q + CHAR_W'(1);
						end else begin
							trunc_d = 1'b1;
						end
					end
					first_d = 1'b0;
					left_d  = frame_byte;
				end
			end
			dqne_pkg::PH_LABEL: begin
				if (take) begin
					valid   = 1'b1;
					ch      = frame_byte;
					chars_d = chars_q + CHAR_W'(1);
				end else begin
					trunc_d = 1'b1;
				end
				left_d = left_q - 8'd1;
			end
			dqne_pkg::PH_SKIP: begin
				valid = 1'b0;
			end
		endcase
	end

	assign push = accept && (valid || done);

	always_comb begin
		push_item.name_char      = ch;
		push_item.char_valid     = valid;
		push_item.name_done      = done;
		push_item.name_truncated = done && trunc_d;
		push_item.source_mac     = mac_d;
		push_item.source_ip      = ip_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			hw_q      <= 4'd0;
			mac_q     <= 48'd0;
			ip_q      <= 32'd0;
			port_hi_q <= 8'd0;
			phase_q   <= dqne_pkg::PH_HEADER;
			left_q    <= 8'd0;
			chars_q   <= '0;
			first_q   <= 1'b1;
			trunc_q   <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				off_q     <= '0;
				hw_q      <= 4'd0;
				mac_q     <= 48'd0;
				ip_q      <= 32'd0;
				port_hi_q <= 8'd0;
				phase_q   <= dqne_pkg::PH_HEADER;
				left_q    <= 8'd0;
				chars_q   <= '0;
				first_q   <= 1'b1;
				trunc_q   <= 1'b0;
			end else begin
				if (off_q != dqne_pkg::OFFSET_MAX) off_q <= off_q + OW'(1);
				if (in_hdr && off_q == ETH) hw_q <= frame_byte[3:0];
				if (in_hdr && off_q > ETH && off_q == udp + OW'(2)) port_hi_q <= frame_byte;
				mac_q   <= mac_d;
				ip_q    <= ip_d;
				phase_q <= phase_d;
				left_q  <= left_d;
				chars_q <= chars_d;
				first_q <= first_d;
				trunc_q <= trunc_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dqne_queue.sv
// ----------------------------------------------------------------------------
// dqne_queue
// Short FIFO of result items between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dqne_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire dqne_pkg::item_t      push_item,
	input  wire logic                 pop,
	output dqne_pkg::item_t           pop_item,
	output dqne_pkg::q_stat_t         q_stat
);

	dqne_pkg::item_t                   store_q [dqne_pkg::QUEUE_DEPTH];
	logic [dqne_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [dqne_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [dqne_pkg::QCNT_W-1:0]       count_q;

	assign q_stat.full  = (count_q == dqne_pkg::QCNT_W'(dqne_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_item     = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) store_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + dqne_pkg::QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + dqne_pkg::QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + dqne_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - dqne_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dqne_back.sv
// ----------------------------------------------------------------------------
// dqne_back
// Output stage: pulls items from the queue into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dqne_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dqne_pkg::q_stat_t    q_stat,
	input  wire dqne_pkg::item_t      pop_item,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output dqne_pkg::item_t           out_item
);

	logic            out_valid_q;
	dqne_pkg::item_t out_item_q;

	// load when the register is empty or its item leaves this cycle
	assign pop       = !q_stat.empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) out_item_q <= pop_item;
	end

endmodule

`default_nettype wire

// File: rtl/core/dns_query_name_extractor_unit.sv
// ----------------------------------------------------------------------------
// dns_query_name_extractor_unit
// Picks the first DNS question name out of matching Ethernet frames.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one frame byte per item, with
// frame_end on the last byte. Output channel (out_valid/out_ready) carries
// one name character per item, with the frame's source MAC and IP; the final
// item of a name has name_done set, plus name_truncated if characters beyond
// MAX_NAME_CHARS were dropped. Frames whose IPv4 source differs from the
// watched address, whose UDP destination port is not 53, or whose DNS opcode
// is non-zero produce nothing.
// Throughput: one byte per cycle while the queue is not full; the parser
// handles each byte as it is accepted. Each result is written into the queue
// on the edge that takes its byte, and is then moved to the output register.
// A four-item queue sits between the parser and the output register; while
// the receiver stalls the queue fills and in_ready falls once full.
// Reset clears the watched address and all parse state; in_ready is high
// straight away. The user must write the address through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_query_name_extractor_unit #(
	parameter int MAX_NAME_CHARS   = 64,
	parameter int ETH_HEADER_BYTES = 14
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       name_char,
	output logic             char_valid,
	output logic             name_done,
	output logic             name_truncated,
	output logic [47:0]      source_mac,
	output logic [31:0]      source_ip
);

	logic [31:0]        watch_ip_q;
	dqne_pkg::q_stat_t  q_stat;
	logic               push;
	logic               pop;
	dqne_pkg::item_t    push_item;
	dqne_pkg::item_t    pop_item;
	dqne_pkg::item_t    out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_ip_q <= 32'd0;
		end else if (cfg_wr_en) begin
			watch_ip_q <= cfg_wr_data;
		end
	end

	dqne_front #(
		.MAX_NAME_CHARS   (MAX_NAME_CHARS),
		.ETH_HEADER_BYTES (ETH_HEADER_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.watch_ip   (watch_ip_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.q_stat     (q_stat),
		.push       (push),
		.push_item  (push_item)
	);

	dqne_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	dqne_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_item  (pop_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign name_char      = out_item.name_char;
	assign char_valid     = out_item.char_valid;
	assign name_done      = out_item.name_done;
	assign name_truncated = out_item.name_truncated;
	assign source_mac     = out_item.source_mac;
	assign source_ip      = out_item.source_ip;

	// truncation is only reported on the closing item of a name
	a_trunc_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_truncated |-> name_done)
		else $error("truncation flag without name end");

	// an item without a character must be a name end, and carries a zero char
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> name_done && name_char == 8'd0)
		else $error("empty item that does not close a name");

	// nothing is written into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("item pushed into full queue");

	// the output register is refilled whenever it drains with items queued
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty && !out_valid |=> out_valid)
		else $error("queued item not moved to output");

endmodule

`default_nettype wire

// File: tb/tb_dns_query_name_extractor_unit.sv
// ----------------------------------------------------------------------------
// tb_dns_query_name_extractor_unit
// Drives Ethernet/IPv4/UDP/DNS frames byte by byte into the query name
// extractor under random idling on both channels. A byte-level predictor of
// the parser runs on every accepted input item, and each result item is
// compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dns_query_name_extractor_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NAME_MAX   = 64;
	localparam int ETH_BYTES  = 14;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_PAD  = 8;

	typedef logic [7:0] octet_q[$];

	// ------------------------------------------------------------------
	// byte-level predictor plus the queue of names still owed by the block
	// ------------------------------------------------------------------
	class qname_scoreboard;
		logic [31:0]      watch_ip;
		logic [10:0]      offset;
		logic [3:0]       ihl;
		logic [47:0]      mac;
		logic [31:0]      ip;
		logic [15:0]      port;
		dqne_pkg::phase_t phase;
		logic [7:0]       left;
		int unsigned      emitted;
		bit               first_lbl;
		bit               trunc;
		dqne_pkg::item_t  expected_chars[$];
		int               errors;
		int               n_bytes;
		int               n_checked;
		int               n_names;
		int               n_trunc;

		function new();
			watch_ip  = '0;
			errors    = 0;
			n_bytes   = 0;
			n_checked = 0;
			n_names   = 0;
			n_trunc   = 0;
			restart();
		endfunction

		function void restart();
			offset    = '0;
			ihl       = '0;
			mac       = '0;
			ip        = '0;
			port      = '0;
			phase     = dqne_pkg::PH_HEADER;
			left      = '0;
			emitted   = 0;
			first_lbl = 1'b1;
			trunc     = 1'b0;
		endfunction

		// counts a character or dot against the name bound
		function bit fits();
			if (emitted < NAME_MAX) begin
				emitted++;
				return 1'b1;
			end
			trunc = 1'b1;
			return 1'b0;
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			int unsigned     off;
			int unsigned     udp;
			bit              got_char;
			bit              done;
			logic [7:0]      ch;
			dqne_pkg::item_t r;
			off      = 32'(offset);
			got_char = 1'b0;
			done     = 1'b0;
			ch       = '0;
			n_bytes++;
			case (phase)
				dqne_pkg::PH_HEADER: begin
					if (off >= 6 && off < 12)
						mac = {mac[39:0], b};
					if (off == ETH_BYTES) begin
						ihl = b[3:0];
						if (ihl < dqne_pkg::IHL_MIN)
							phase = dqne_pkg::PH_SKIP;
					end else if (off > ETH_BYTES) begin
						udp = ETH_BYTES + 4 * ihl;
						if (off >= ETH_BYTES + 12 && off < ETH_BYTES + 16)
							ip = {ip[23:0], b};
						if (off == udp + 2) begin
							port = {b, 8'h00};
						end else if (off == udp + 3) begin
							port = {port[15:8], b};
							if (port != dqne_pkg::DNS_PORT || ip != watch_ip)
								phase = dqne_pkg::PH_SKIP;
						end else if (off == udp + 10) begin
							if (b[6:3] != 4'd0)
								phase = dqne_pkg::PH_SKIP;
						end else if (off == udp + 19) begin
							phase     = dqne_pkg::PH_LENGTH;
							first_lbl = 1'b1;
							emitted   = 0;
							trunc     = 1'b0;
							left      = '0;
						end
					end
				end
				dqne_pkg::PH_LENGTH: begin
					if (b == 8'd0) begin
						done  = 1'b1;
						phase = dqne_pkg::PH_SKIP;
					end else begin
						if (!first_lbl && fits()) begin
							got_char = 1'b1;
							ch       = dqne_pkg::NAME_DOT;
						end
						first_lbl = 1'b0;
						left      = b;
						phase     = dqne_pkg::PH_LABEL;
					end
				end
				dqne_pkg::PH_LABEL: begin
					if (fits()) begin
						got_char = 1'b1;
						ch       = b;
					end
					left = left - 8'd1;
					if (left == 8'd0)
						phase = dqne_pkg::PH_LENGTH;
				end
				default: ;
			endcase

			if (last && (phase == dqne_pkg::PH_LENGTH || phase == dqne_pkg::PH_LABEL))
				done = 1'b1;

			if (got_char || done) begin
				r.name_char      = got_char ? ch : 8'd0;
				r.char_valid     = got_char;
				r.name_done      = done;
				r.name_truncated = done && trunc;
				r.source_mac     = mac;
				r.source_ip      = ip;
				expected_chars.push_back(r);
			end

			if (last) begin
				restart();
			end else begin
				if (done)
					phase = dqne_pkg::PH_SKIP;
				if (offset != dqne_pkg::OFFSET_MAX)
					offset++;
			end
		endfunction

		function void cmp(string what, logic [47:0] want, logic [47:0] seen);
			if (want !== seen) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, got %0h",
					$time, what, want, seen);
			end
		endfunction

		function void check_char(dqne_pkg::item_t got);
			dqne_pkg::item_t want;
			if (expected_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, got char %0h done %0b",
					$time, got.name_char, got.name_done);
				return;
			end
			want = expected_chars.pop_front();
			cmp("name_char", 48'(want.name_char), 48'(got.name_char));
			cmp("char_valid", 48'(want.char_valid), 48'(got.char_valid));
			cmp("name_done", 48'(want.name_done), 48'(got.name_done));
			cmp("name_truncated", 48'(want.name_truncated), 48'(got.name_truncated));
			cmp("source_mac", want.source_mac, got.source_mac);
			cmp("source_ip", 48'(want.source_ip), 48'(got.source_ip));
			n_checked++;
			if (want.name_done)
				n_names++;
			if (want.name_truncated)
				n_trunc++;
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT and its surroundings
	// ------------------------------------------------------------------
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  frame_byte  = '0;
	logic        frame_end   = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b1;
	logic [7:0]  name_char;
	logic        char_valid;
	logic        name_done;
	logic        name_truncated;
	logic [47:0] source_mac;
	logic [31:0] source_ip;

	qname_scoreboard sb = new();

	bit calm       = 1'b0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int frames_sent  = 0;
	int targets_used = 0;
	int idle_cycles  = 0;

	dns_query_name_extractor_unit #(
		.MAX_NAME_CHARS  (NAME_MAX),
		.ETH_HEADER_BYTES(ETH_BYTES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.frame_byte    (frame_byte),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.name_char     (name_char),
		.char_valid    (char_valid),
		.name_done     (name_done),
		.name_truncated(name_truncated),
		.source_mac    (source_mac),
		.source_ip     (source_ip)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// handshakes are sampled at the rising edge
	always @(posedge clk) begin
		dqne_pkg::item_t got;
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_byte(frame_byte, frame_end);
			if (out_valid && out_ready) begin
				got.name_char      = name_char;
				got.char_valid     = char_valid;
				got.name_done      = name_done;
				got.name_truncated = name_truncated;
				got.source_mac     = source_mac;
				got.source_ip      = source_ip;
				sb.check_char(got);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		forever begin
			@(negedge clk);
			if (!calm && rx_idle_en && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// frame construction
	// ------------------------------------------------------------------
	function automatic octet_q make_name(int labels, int lo, int hi, bit terminated);
		octet_q q;
		int     len;
		for (int i = 0; i < labels; i++) begin
			len = $urandom_range(lo, hi);
			q.push_back(len[7:0]);
			repeat (len) begin
				if ($urandom_range(0, 3) == 0)
					q.push_back(8'($urandom_range(0, 255)));
				else
					q.push_back(8'h61 + 8'($urandom_range(0, 25)));
			end
		end
		if (terminated)
			q.push_back(8'h00);
		return q;
	endfunction

	function automatic octet_q make_frame(logic [31:0] src, logic [3:0] hdr_words,
			bit bad_port, bit bad_op, octet_q qname, int tail);
		octet_q      f;
		int          ip_len;
		logic [15:0] dport;
		logic [7:0]  flags;
		repeat (12) f.push_back(8'($urandom_range(0, 255)));
		f.push_back(8'h08);
		f.push_back(8'h00);
		// IPv4 header; a short IHL still gets a full 20-byte header on the wire
		ip_len = (hdr_words < dqne_pkg::IHL_MIN) ? 20 : 4 * hdr_words;
		f.push_back({4'h4, hdr_words});
		for (int i = 1; i < ip_len; i++) begin
			if (i >= 12 && i < 16)
				f.push_back(src[31 - 8 * (i - 12) -: 8]);
			else
				f.push_back(8'($urandom_range(0, 255)));
		end
		// UDP header
		dport = dqne_pkg::DNS_PORT;
		if (bad_port) begin
			dport = 16'($urandom_range(0, 65535));
			if (dport == dqne_pkg::DNS_PORT)
				dport = 16'h3500;
		end
		f.push_back(8'($urandom_range(0, 255)));
		f.push_back(8'($urandom_range(0, 255)));
		f.push_back(dport[15:8]);
		f.push_back(dport[7:0]);
		repeat (4) f.push_back(8'($urandom_range(0, 255)));
		// DNS header, opcode in bits 6..3 of the third byte
		flags      = 8'($urandom_range(0, 255));
		flags[6:3] = bad_op ? 4'($urandom_range(1, 15)) : 4'd0;
		f.push_back(8'($urandom_range(0, 255)));
		f.push_back(8'($urandom_range(0, 255)));
		f.push_back(flags);
		repeat (9) f.push_back(8'($urandom_range(0, 255)));
		foreach (qname[i])
			f.push_back(qname[i]);
		repeat (tail) f.push_back(8'($urandom_range(0, 255)));
		return f;
	endfunction

	// ------------------------------------------------------------------
	// driving tasks
	// ------------------------------------------------------------------
	task automatic send_byte(logic [7:0] b, logic last);
		if (!calm && tx_idle_en && $urandom_range(0, 7) == 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		frame_byte <= b;
		frame_end  <= last;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_frame(octet_q f);
		tx_idle_en = $urandom_range(0, 3) != 0;
		rx_idle_en = $urandom_range(0, 3) != 0;
		foreach (f[i])
			send_byte(f[i], i == f.size() - 1);
		frames_sent++;
	endtask

	// sender holds off until every predicted item has come out
	task automatic wait_results();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.expected_chars.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_target(logic [31:0] value);
		wait_results();
		repeat (DRAIN_PAD) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk) cfg_wr_en <= 1'b0;
		sb.watch_ip = value;
		targets_used++;
	endtask

	task automatic random_traffic(int nbytes);
		int          stop_at;
		int          sel;
		int          cut;
		logic [31:0] src;
		logic [3:0]  hw;
		octet_q      qn;
		octet_q      f;
		stop_at = sb.n_bytes + nbytes;
		while (sb.n_bytes < stop_at) begin
			sel = $urandom_range(0, 19);
			src = sb.watch_ip;
			hw  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
			if ($urandom_range(0, 9) == 0)
				qn = make_name(0, 1, 1, 1);
			else if ($urandom_range(0, 7) == 0)
				qn = make_name($urandom_range(1, 2), 60, 255, $urandom_range(0, 7) != 0);
			else
				qn = make_name($urandom_range(1, 4), 1, $urandom_range(1, 20),
					$urandom_range(0, 7) != 0);
			if (sel == 13)
				src = ($urandom_range(0, 1) == 0) ? src ^ (32'd1 << $urandom_range(0, 31))
					: 32'($urandom);
			if (sel == 16)
				hw = 4'($urandom_range(0, 4));
			if (sel >= 17) begin
				f = {};
				repeat ($urandom_range(1, 40)) f.push_back(8'($urandom_range(0, 255)));
			end else begin
				f = make_frame(src, hw, sel == 14, sel == 15, qn, $urandom_range(0, 6));
			end
			if ($urandom_range(0, 6) == 0) begin
				cut = $urandom_range(1, f.size());
				f = f[0:cut - 1];
			end
			send_frame(f);
			if ($urandom_range(0, 11) == 0)
				wait_results();
		end
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [31:0] tgt;
		octet_q      qn;
		octet_q      f;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset value of the target first
		write_target(32'h0000_0000);
		send_frame(make_frame(32'h0, 4'd5, 1'b0, 1'b0, make_name(2, 1, 6, 1), 4));

		tgt = 32'hC0A8_0A01;
		write_target(tgt);
		send_frame(make_frame(tgt, 4'd5, 1'b0, 1'b0, make_name(3, 2, 8, 1), 4));
		// empty name
		send_frame(make_frame(tgt, 4'd5, 1'b0, 1'b0, make_name(0, 1, 1, 1), 3));
		// mismatches: address, port, opcode, short IHL
		send_frame(make_frame(tgt ^ 32'h1, 4'd5, 1'b0, 1'b0, make_name(2, 1, 6, 1), 2));
		send_frame(make_frame(tgt ^ 32'h8000_0000, 4'd5, 1'b0, 1'b0, make_name(1, 3, 6, 1), 0));
		send_frame(make_frame(tgt, 4'd5, 1'b1, 1'b0, make_name(2, 1, 6, 1), 2));
		send_frame(make_frame(tgt, 4'd5, 1'b0, 1'b1, make_name(2, 1, 6, 1), 2));
		send_frame(make_frame(tgt, 4'd4, 1'b0, 1'b0, make_name(2, 1, 6, 1), 2));
		send_frame(make_frame(tgt, 4'd0, 1'b0, 1'b0, make_name(2, 1, 6, 1), 2));
		// largest IPv4 header
		send_frame(make_frame(tgt, 4'd15, 1'b0, 1'b0, make_name(2, 1, 6, 1), 2));
		// frame ends on the last DNS header byte
		send_frame(make_frame(tgt, 4'd5, 1'b0, 1'b0, make_name(0, 1, 1, 0), 0));
		// frame ends before the name
		f = make_frame(tgt, 4'd5, 1'b0, 1'b0, make_name(2, 1, 6, 1), 0);
		send_frame(f[0:29]);
		// frame ends inside a label, then on a length byte
		send_frame(make_frame(tgt, 4'd5, 1'b0, 1'b0, make_name(2, 3, 7, 0), 0));
		qn = make_name(2, 3, 5, 0);
		qn.push_back(8'($urandom_range(1, 255)));
		send_frame(make_frame(tgt, 4'd5, 1'b0, 1'b0, qn, 0));
		// extreme byte values inside a label
		qn = '{8'd4, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'd0};
		send_frame(make_frame(tgt, 4'd5, 1'b0, 1'b0, qn, 1));
		// length byte above 127, and a name past the bound
		send_frame(make_frame(tgt, 4'd5, 1'b0, 1'b0, make_name(1, 130, 130, 1), 2));
		send_frame(make_frame(tgt, 4'd5, 1'b0, 1'b0, make_name(5, 13, 16, 1), 2));
		// single-byte frame
		send_frame('{8'hFF});

		write_target(32'hFFFF_FFFF);
		send_frame(make_frame(32'hFFFF_FFFF, 4'd5, 1'b0, 1'b0, make_name(2, 1, 6, 1), 1));
		send_frame(make_frame(32'hFFFF_FFFE, 4'd5, 1'b0, 1'b0, make_name(2, 1, 6, 1), 1));
		random_traffic(60);

		write_target($urandom);
		random_traffic(60);

		// last stretch runs without any idling
		write_target($urandom);
		calm = 1'b1;
		random_traffic(90);

		wait_results();
		repeat (DRAIN_PAD) @(negedge clk);

		$display("Covered %0d frames, %0d bytes, %0d target addresses incl. 0 and all-ones.",
			frames_sent, sb.n_bytes, targets_used);
		$display("Checked %0d output items: %0d names finished, %0d of them truncated.",
			sb.n_checked, sb.n_names, sb.n_trunc);
		if (sb.errors == 0 && sb.expected_chars.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
